// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GCEG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define GCEG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define GCEG_ASSERT(lbl, prop)
`define GCEG_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/gceg_pkg.sv =====
// Package: types and constants of the gamepad change event generator.
`default_nettype none
package gceg_pkg;

  localparam int ButtonCount = 16;
  localparam int AxisCount   = 4;
  localparam int TrigCount   = 2;
  localparam int EventCount  = ButtonCount + AxisCount + TrigCount;
  localparam int EventIdxW   = $clog2(EventCount);
  localparam int ButtonIdxW  = $clog2(ButtonCount);
  localparam int AxisIdxW    = $clog2(AxisCount);
  localparam int AxisW       = 16;
  localparam int TrigW       = 8;
  localparam int FullScaleW  = 15;
  localparam int DeadzoneW   = 7;
  localparam int ThreshW     = FullScaleW + DeadzoneW;
  localparam int ScaledW     = 24;
  localparam int CfgDataW    = 15;
  localparam int CfgIdxW     = 1;

  localparam logic [FullScaleW-1:0] FullScaleReset = 15'd32767;
  localparam logic [DeadzoneW-1:0]  DeadzoneReset  = 7'd10;
  localparam logic [ScaledW-1:0]    PercentScale   = 24'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAxisFullScale   = 1'b0,
    CfgDeadzonePercent = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    KindPress   = 2'd0,
    KindRelease = 2'd1,
    KindAxis    = 2'd2,
    KindTrigger = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [15:0]        button_bits;
    logic signed [15:0] axis_zero;
    logic signed [15:0] axis_one;
    logic signed [15:0] axis_two;
    logic signed [15:0] axis_three;
    logic [7:0]         trigger_left;
    logic [7:0]         trigger_right;
  } in_req_t;

  typedef struct packed {
    event_kind_e        event_kind;
    logic [3:0]         event_index;
    logic signed [15:0] event_value;
    logic               last_event;
  } out_req_t;

  // What the compare stage hands to the emitter.
  typedef struct packed {
    logic                  valid;
    logic [EventCount-1:0] mask;
    in_req_t               report;
  } found_t;

endpackage
`default_nettype wire

// ===== hdl/gceg_axis_lane.sv =====
// One stick axis lane: change detect and deadzone test.
`default_nettype none
module gceg_axis_lane
  import gceg_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic signed [AxisW-1:0]  axis_i,
  input  wire logic [ThreshW-1:0]       threshold_i,
  output logic                          hit_o
);

  logic [AxisW-1:0]   prev_q;
  logic               changed_q;
  logic [ScaledW-1:0] scaled_q;
  logic [AxisW:0]     ext;
  logic [AxisW:0]     mag;

  assign ext = {axis_i[AxisW-1], axis_i};
  assign mag = axis_i[AxisW-1] ? (AxisW+1)'(-ext) : ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      changed_q <= 1'b0;
    end else if (load_i) begin
      prev_q    <= axis_i;
      changed_q <= (axis_i != prev_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= ScaledW'(mag) * PercentScale;
    end
  end

  assign hit_o = changed_q && (scaled_q > ScaledW'(threshold_i));

endmodule
`default_nettype wire

// ===== hdl/gceg_emitter.sv =====
// Event emitter: walks the event mask lowest first, one request per cycle unless stalled.
`default_nettype none
module gceg_emitter
  import gceg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire found_t   found_i,
  output logic          load_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  logic [EventCount-1:0] mask_q;
  in_req_t               report_q;
  logic                  o_valid_q;
  out_req_t              o_req_q;

  logic [EventCount-1:0] onehot;
  logic [EventCount-1:0] rest;
  logic [EventIdxW-1:0]  pos;
  logic [EventIdxW-1:0]  sub;
  logic                  emit;
  out_req_t              req;
  logic [AxisW-1:0]      axis_val [AxisCount];

  assign axis_val[0] = report_q.axis_zero;
  assign axis_val[1] = report_q.axis_one;
  assign axis_val[2] = report_q.axis_two;
  assign axis_val[3] = report_q.axis_three;

  assign onehot = mask_q & (~mask_q + EventCount'(1));
  assign rest   = mask_q & ~onehot;
  assign emit   = (mask_q != '0) && (!o_valid_q || !out_stall_i);
  assign load_ready_o = (mask_q == '0) || (emit && (rest == '0));

  always_comb begin
    pos = '0;
    for (int i = 0; i < EventCount; i++) begin
      if (onehot[i]) begin
        pos = pos | EventIdxW'(i);
      end
    end
  end

  always_comb begin
    req            = '0;
    sub            = '0;
    req.last_event = (rest == '0);
    if (pos < EventIdxW'(ButtonCount)) begin
      req.event_kind  = report_q.button_bits[pos[ButtonIdxW-1:0]] ? KindPress : KindRelease;
      req.event_index = 4'(pos);
    end else if (pos < EventIdxW'(ButtonCount + AxisCount)) begin
      sub             = pos - EventIdxW'(ButtonCount);
      req.event_kind  = KindAxis;
      req.event_index = 4'(sub);
      req.event_value = axis_val[sub[AxisIdxW-1:0]];
    end else begin
      sub             = pos - EventIdxW'(ButtonCount + AxisCount);
      req.event_kind  = KindTrigger;
      req.event_index = 4'(sub);
      req.event_value = sub[0] ? AxisW'(report_q.trigger_right)
                               : AxisW'(report_q.trigger_left);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (found_i.valid && load_ready_o) begin
        mask_q <= found_i.mask;
      end else if (emit) begin
        mask_q <= rest;
      end
      if (emit) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (found_i.valid && load_ready_o) begin
      report_q <= found_i.report;
    end
    if (emit) begin
      o_req_q <= req;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_req_o   = o_req_q;

endmodule
`default_nettype wire

// ===== hdl/gamepad_change_event_generator.sv =====
// Top level: gamepad change event generator.
//
// Input channel in_valid_i / in_stall_o / in_req_i carries one gamepad report per
// request. Each report is compared with the previous one in parallel lanes (buttons,
// four axis lanes with deadzone test, two triggers); the changes found are emitted
// on out_valid_o / out_stall_i / out_req_o, one event request per cycle unless stalled:
// buttons in ascending order, then axes, then left and right trigger. last_event marks
// the final event of a report; a report without changes yields nothing.
// Each report passes the compare stage, then the emitter mask, then the event register.
// Throughput: one event per cycle unless stalled, set by the single emitter; the next
// report is taken while the emitter still works on the previous one.
// A stall on the output holds the event register, and the input stalls once the
// compare stage is full. Reset clears the stored report to zero, sets full scale to
// 32767 and deadzone to 10 percent. Configuration writes go through cfg_we_i.
`default_nettype none
module gamepad_change_event_generator
  import gceg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_req_t              in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_req_t                  out_req_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i
);

`include "assert_macros.svh"

  logic [FullScaleW-1:0] full_scale_q;
  logic [DeadzoneW-1:0]  deadzone_q;
  logic [ThreshW-1:0]    threshold;

  logic                  a_valid_q;
  in_req_t               a_report_q;
  logic [ButtonCount-1:0] prev_buttons_q;
  logic [TrigW-1:0]      prev_tl_q;
  logic [TrigW-1:0]      prev_tr_q;
  logic [ButtonCount-1:0] a_btn_diff_q;
  logic [TrigCount-1:0]  a_trig_chg_q;
  logic [AxisCount-1:0]  axis_hit;
  logic [AxisW-1:0]      axes [AxisCount];

  logic                  in_acc;
  logic                  load_ready;
  found_t                found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FullScaleReset;
      deadzone_q   <= DeadzoneReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAxisFullScale:   full_scale_q <= cfg_wdata_i[FullScaleW-1:0];
        CfgDeadzonePercent: deadzone_q   <= cfg_wdata_i[DeadzoneW-1:0];
        default: ;
      endcase
    end
  end

  assign threshold = ThreshW'(full_scale_q) * ThreshW'(deadzone_q);

  assign in_stall_o = a_valid_q && !load_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign axes[0] = in_req_i.axis_zero;
  assign axes[1] = in_req_i.axis_one;
  assign axes[2] = in_req_i.axis_two;
  assign axes[3] = in_req_i.axis_three;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q      <= 1'b0;
      prev_buttons_q <= '0;
      prev_tl_q      <= '0;
      prev_tr_q      <= '0;
      a_btn_diff_q   <= '0;
      a_trig_chg_q   <= '0;
    end else begin
      if (in_acc) begin
        a_valid_q      <= 1'b1;
        prev_buttons_q <= in_req_i.button_bits;
        prev_tl_q      <= in_req_i.trigger_left;
        prev_tr_q      <= in_req_i.trigger_right;
        a_btn_diff_q   <= in_req_i.button_bits ^ prev_buttons_q;
        a_trig_chg_q   <= {in_req_i.trigger_right != prev_tr_q,
                           in_req_i.trigger_left != prev_tl_q};
      end else if (load_ready) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_report_q <= in_req_i;
    end
  end

  for (genvar g = 0; g < AxisCount; g++) begin : g_axis
    gceg_axis_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (in_acc),
      .axis_i      (axes[g]),
      .threshold_i (threshold),
      .hit_o       (axis_hit[g])
    );
  end

  assign found.valid  = a_valid_q;
  assign found.mask   = {a_trig_chg_q, axis_hit, a_btn_diff_q};
  assign found.report = a_report_q;

  gceg_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .found_i      (found),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_req_o    (out_req_o)
  );

  `GCEG_ASSERT(a_fills_on_accept, in_acc |=> a_valid_q)
  `GCEG_ASSERT_NEVER(button_value_nonzero,
    out_valid_o && (out_req_o.event_kind == KindPress ||
    out_req_o.event_kind == KindRelease) && out_req_o.event_value != '0)
  `GCEG_ASSERT_NEVER(trigger_index_range,
    out_valid_o && out_req_o.event_kind == KindTrigger && out_req_o.event_index[3:1] != '0)

endmodule
`default_nettype wire

// ===== dv/tb_gamepad_change_event_generator.sv =====
// Testbench for the gamepad change event generator: directed and random reports against a predictor.
module tb_gamepad_change_event_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import gceg_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned SegmentItems = 25;

  class gamepad_event_scoreboard;
    int unsigned full_scale = 32767;
    int unsigned deadzone   = 10;
    logic [15:0] last_buttons = '0;
    logic signed [15:0] last_axes [4] = '{default: '0};
    logic [7:0] last_trig_left  = '0;
    logic [7:0] last_trig_right = '0;
    out_req_t expected_events [$];
    int unsigned mismatches = 0;

    function void set_register(cfg_index_e idx, int unsigned val);
      case (idx)
        CfgAxisFullScale:   full_scale = val & 32'h7fff;
        CfgDeadzonePercent: deadzone   = val & 32'h7f;
        default: ;
      endcase
    endfunction

    function int unsigned axis_magnitude(logic [15:0] raw);
      return raw[15] ? (32'h10000 - 32'(raw)) : 32'(raw);
    endfunction

    function void note_report(in_req_t r);
      logic signed [15:0] axes [4];
      out_req_t found [$];
      out_req_t ev;
      int unsigned threshold;
      axes[0] = r.axis_zero;
      axes[1] = r.axis_one;
      axes[2] = r.axis_two;
      axes[3] = r.axis_three;
      threshold = full_scale * deadzone;
      ev.last_event = 1'b0;
      for (int i = 0; i < ButtonCount; i++) begin
        if (r.button_bits[i] != last_buttons[i]) begin
          ev.event_kind  = r.button_bits[i] ? KindPress : KindRelease;
          ev.event_index = 4'(i);
          ev.event_value = '0;
          found.push_back(ev);
        end
      end
      for (int i = 0; i < AxisCount; i++) begin
        if (axes[i] != last_axes[i] && axis_magnitude(axes[i]) * 100 > threshold) begin
          ev.event_kind  = KindAxis;
          ev.event_index = 4'(i);
          ev.event_value = axes[i];
          found.push_back(ev);
        end
      end
      if (r.trigger_left != last_trig_left) begin
        ev.event_kind  = KindTrigger;
        ev.event_index = 4'd0;
        ev.event_value = 16'(r.trigger_left);
        found.push_back(ev);
      end
      if (r.trigger_right != last_trig_right) begin
        ev.event_kind  = KindTrigger;
        ev.event_index = 4'd1;
        ev.event_value = 16'(r.trigger_right);
        found.push_back(ev);
      end
      for (int j = 0; j < found.size(); j++) begin
        ev = found[j];
        ev.last_event = (j == found.size() - 1);
        expected_events.push_back(ev);
      end
      last_buttons = r.button_bits;
      for (int i = 0; i < AxisCount; i++) last_axes[i] = axes[i];
      last_trig_left  = r.trigger_left;
      last_trig_right = r.trigger_right;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_event(out_req_t got);
      out_req_t want;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d index %0d",
                                  got.event_kind, got.event_index));
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind)
        report_mismatch($sformatf("event_kind got %0d expected %0d",
                                  got.event_kind, want.event_kind));
      if (got.event_index !== want.event_index)
        report_mismatch($sformatf("event_index got %0d expected %0d",
                                  got.event_index, want.event_index));
      if (got.event_value !== want.event_value)
        report_mismatch($sformatf("event_value got %0d expected %0d (kind %0d index %0d)",
                                  got.event_value, want.event_value,
                                  want.event_kind, want.event_index));
      if (got.last_event !== want.last_event)
        report_mismatch($sformatf("last_event got %0b expected %0b (kind %0d index %0d)",
                                  got.last_event, want.last_event,
                                  want.event_kind, want.event_index));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_req_t out_req;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 59;
  int unsigned cycle_count = 0;
  in_req_t last_sent = '0;
  gamepad_event_scoreboard sb = new;

  gamepad_change_event_generator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_event(out_req);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_req_t make_report(logic [15:0] buttons, int a0, int a1, int a2,
                                          int a3, logic [7:0] tl, logic [7:0] tr);
    in_req_t r;
    r.button_bits   = buttons;
    r.axis_zero     = 16'(a0);
    r.axis_one      = 16'(a1);
    r.axis_two      = 16'(a2);
    r.axis_three    = 16'(a3);
    r.trigger_left  = tl;
    r.trigger_right = tr;
    return r;
  endfunction

  function automatic in_req_t next_report(in_req_t prev);
    in_req_t r;
    logic signed [15:0] axes [4];
    int unsigned near_mag;
    int m;
    r = prev;
    case ($urandom_range(19))
      0, 1: ;
      2, 3: begin
        r.button_bits   = 16'($urandom);
        r.axis_zero     = 16'($urandom);
        r.axis_one      = 16'($urandom);
        r.axis_two      = 16'($urandom);
        r.axis_three    = 16'($urandom);
        r.trigger_left  = 8'($urandom);
        r.trigger_right = 8'($urandom);
      end
      default: begin
        near_mag = (sb.full_scale * sb.deadzone) / 100;
        axes[0] = r.axis_zero;
        axes[1] = r.axis_one;
        axes[2] = r.axis_two;
        axes[3] = r.axis_three;
        if ($urandom_range(1)) r.button_bits ^= 16'(1) << $urandom_range(15);
        else r.button_bits ^= 16'($urandom & $urandom & $urandom);
        for (int i = 0; i < 4; i++) begin
          if ($urandom_range(1)) begin
            case ($urandom_range(3))
              0: begin
                m = int'(near_mag) + int'($urandom_range(4)) - 2;
                if (m < 0) m = 0;
                if (m > 32767) m = 32767;
                axes[i] = 16'($urandom_range(1) ? -m : m);
              end
              1: axes[i] = 16'($urandom);
              2: begin
                case ($urandom_range(2))
                  0: axes[i] = 16'sh7fff;
                  1: axes[i] = 16'sh8000;
                  default: axes[i] = '0;
                endcase
              end
              default: axes[i] = 16'(int'($urandom_range(8)) - 4);
            endcase
          end
        end
        r.axis_zero  = axes[0];
        r.axis_one   = axes[1];
        r.axis_two   = axes[2];
        r.axis_three = axes[3];
        if ($urandom_range(2) == 0) r.trigger_left = 8'($urandom);
        if ($urandom_range(2) == 0) r.trigger_right = 8'($urandom);
      end
    endcase
    return r;
  endfunction

  task automatic send_report(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(negedge clk_i); while (in_stall);
    sb.note_report(r);
    last_sent = r;
    @(posedge clk_i);
  endtask

  // hold off new requests until every pending event is out and the emitter is idle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_events.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_index_e idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgDataW'(val);
    @(posedge clk_i);
    sb.set_register(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full scale 32767, deadzone 10 percent
    send_report(make_report(16'h0000, 0, 0, 0, 0, 8'h00, 8'h00));
    send_report(make_report(16'hffff, 32767, -32768, 3277, -3277, 8'hff, 8'hff));
    send_report(make_report(16'hffff, 32767, -32768, 3277, -3277, 8'hff, 8'hff));
    send_report(make_report(16'h0000, 3276, -3276, 3277, -3277, 8'h00, 8'h00));
    send_report(make_report(16'h0000, 3276, -3276, 3277, -3277, 8'h80, 8'h00));
    send_report(make_report(16'h0000, 3276, -3276, 3277, -3277, 8'h80, 8'h01));
    send_report(make_report(16'h8000, 3276, -3276, 3277, -3277, 8'h80, 8'h01));
    send_report(make_report(16'h0001, 3276, -3276, 3277, -3277, 8'h80, 8'h01));
    send_report(make_report(16'h0001, -1, 1, 0, 0, 8'h80, 8'h01));
    send_report(make_report(16'h0001, -1, 1, 0, 0, 8'h80, 8'h01));
    send_report(make_report(16'haaaa, 32767, 32767, -32768, -32768, 8'h7f, 8'hfe));
    send_report(make_report(16'h5555, -32767, 0, 32767, 1, 8'h00, 8'hff));

    // zero full scale: any nonzero axis reports
    drain();
    write_cfg(CfgAxisFullScale, 0);
    send_report(make_report(16'h5555, 1, -1, 2, 0, 8'h00, 8'hff));
    send_report(make_report(16'h5555, 0, 0, 0, -1, 8'h00, 8'hff));

    drain();
    write_cfg(CfgAxisFullScale, 32767);
    write_cfg(CfgDeadzonePercent, 100);
    send_report(make_report(16'h5555, 32767, -32768, -32767, 0, 8'h00, 8'hff));
    send_report(make_report(16'h5555, -32768, 32767, 100, 5, 8'h00, 8'hff));

    // deadzone above 100: no axis can report
    drain();
    write_cfg(CfgDeadzonePercent, 127);
    send_report(make_report(16'h5555, 32767, -32768, -32768, 32767, 8'h01, 8'hff));

    drain();
    write_cfg(CfgAxisFullScale, 1);
    write_cfg(CfgDeadzonePercent, 0);
    send_report(make_report(16'h5555, 1, -1, 0, 32767, 8'h01, 8'hff));

    drain();
    write_cfg(CfgDeadzonePercent, 100);
    send_report(make_report(16'h5555, 2, -1, 1, -2, 8'h01, 8'hff));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        case ($urandom_range(4))
          0: write_cfg(CfgAxisFullScale, 1);
          1: write_cfg(CfgAxisFullScale, 32767);
          2: write_cfg(CfgAxisFullScale, 0);
          default: write_cfg(CfgAxisFullScale, $urandom_range(32767, 1));
        endcase
        case ($urandom_range(4))
          0: write_cfg(CfgDeadzonePercent, 0);
          1: write_cfg(CfgDeadzonePercent, 100);
          2: write_cfg(CfgDeadzonePercent, 127);
          default: write_cfg(CfgDeadzonePercent, $urandom_range(100));
        endcase
        repeat (SegmentItems) send_report(next_report(last_sent));
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gceg_pkg.sv
hdl/gceg_axis_lane.sv
hdl/gceg_emitter.sv
hdl/gamepad_change_event_generator.sv
dv/tb_gamepad_change_event_generator.sv
